// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a at an edge requires condition c at the same edge.
`define CLA_ASSERT_SAME(label, clk, dis, a, c) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Condition a at an edge requires condition c at the next edge.
`define CLA_ASSERT_NEXT(label, clk, dis, a, c) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cla_pkg.sv =====
// Package with constants, codes and types of the console line assembler.
`timescale 1ns / 1ps
package cla_pkg;

  localparam int LINE_BYTES = 64;
  localparam int CAPACITY   = LINE_BYTES - 1;
  localparam int CNT_W      = $clog2(LINE_BYTES);
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_BYTE   = 8'd255;
  localparam logic [7:0] BS_BYTE    = 8'd8;
  localparam logic [7:0] DEL_BYTE   = 8'd127;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] LF_BYTE    = 8'd10;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;

  localparam logic [7:0] OUT_LIMIT_RESET = 8'd64;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_BACK,
    CMD_EMIT,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] chr;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic full;
    logic empty;
    cmd_t head;
  } cmd_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } back_state_t;

endpackage

// ===== rtl/cla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cla_front.sv =====
// Front end: accepts console items, tracks telnet command skipping, classifies bytes.
`timescale 1ns / 1ps
module cla_front import cla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic        q_full,
  output logic        full,
  output cmd_req_t    req
);

  logic [1:0] command_skip;
  logic [1:0] command_skip_next;
  logic       accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    command_skip_next = command_skip;
    req.push          = 1'b0;
    req.cmd.kind      = CMD_STORE;
    req.cmd.chr       = data_byte;
    if (accept) begin
      priority if (op == OP_RESET) begin
        command_skip_next = 2'd0;
        req.push          = 1'b1;
        req.cmd.kind      = CMD_CLEAR;
      end else if (command_skip != 2'd0) begin
        command_skip_next = command_skip - 2'd1;
      end else if (data_byte == CMD_BYTE) begin
        command_skip_next = 2'd2;
      end else if (data_byte == CR_BYTE || data_byte == LF_BYTE) begin
        req.push     = 1'b1;
        req.cmd.kind = CMD_EMIT;
      end else if (data_byte == BS_BYTE || data_byte == DEL_BYTE) begin
        req.push     = 1'b1;
        req.cmd.kind = CMD_BACK;
      end else if (data_byte >= PRINT_LOW && data_byte <= PRINT_HIGH) begin
        req.push     = 1'b1;
        req.cmd.kind = CMD_STORE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_skip <= 2'd0;
    end else begin
      command_skip <= command_skip_next;
    end
  end

endmodule

// ===== rtl/cla_cmd_queue.sv =====
// Short command queue between the front end and the line engine.
`timescale 1ns / 1ps
module cla_cmd_queue import cla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_req_t    req,
  input  logic        pop,
  output cmd_status_t status
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (cnt == QCNT_W'(QDEPTH));
  assign status.empty = (cnt == '0);
  assign status.head  = slots[rd_ptr];
  assign do_push      = req.push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/cla_back.sv =====
// Line engine: keeps the line store and count, drains completed lines to the result buffer.
`timescale 1ns / 1ps
module cla_back import cla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  cmd_status_t q_status,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_char,
  output logic        last
);

  back_state_t       state;
  back_state_t       state_next;
  logic [7:0]        out_limit;
  logic [CNT_W-1:0]  line_count;
  logic [CNT_W-1:0]  line_count_next;
  logic [CNT_W-1:0]  emit_n;
  logic [CNT_W-1:0]  n_reg;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_pending;
  logic              rd_last;
  logic [1:0]        occ;
  logic [7:0]        head_chr;
  logic              head_last;
  logic [7:0]        tail_chr;
  logic              tail_last;
  logic [7:0]        rdata;
  logic [7:0]        limit;
  logic              issue_ok;
  logic              rd_is_last;
  logic              ram_we;
  logic              ram_re;
  logic              pop_ok;

  assign limit  = (out_limit == 8'd0) ? 8'd0 : out_limit - 8'd1;
  assign emit_n = ({{(8 - CNT_W + 1){1'b0}}, line_count} < {1'b0, limit}) ?
                  line_count : CNT_W'(limit);

  assign issue_ok   = ({1'b0, rd_pending} + occ) < 2'd2;
  assign rd_is_last = (CNT_W'(rd_addr) == n_reg - 1'b1);
  assign pop_ok     = pop && (occ != 2'd0);

  assign empty    = (occ == 2'd0);
  assign out_char = head_chr;
  assign last     = head_last;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty && q_status.head.kind == CMD_EMIT && emit_n != '0) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (issue_ok && rd_is_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    line_count_next = line_count;
    unique case (state)
      BK_IDLE: begin
        q_pop = !q_status.empty;
        if (!q_status.empty) begin
          unique case (q_status.head.kind)
            CMD_STORE: begin
              if (line_count < CNT_W'(CAPACITY)) begin
                ram_we          = 1'b1;
                line_count_next = line_count + 1'b1;
              end
            end
            CMD_BACK: begin
              if (line_count != '0) begin
                line_count_next = line_count - 1'b1;
              end
            end
            CMD_EMIT:  line_count_next = '0;
            CMD_CLEAR: line_count_next = '0;
            default:   line_count_next = line_count;
          endcase
        end
      end
      BK_DRAIN: begin
        ram_re = issue_ok;
      end
      default: ram_re = 1'b0;
    endcase
  end

  cla_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(line_count[ADDR_W-1:0]),
    .wdata(q_status.head.chr),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      out_limit  <= OUT_LIMIT_RESET;
      line_count <= '0;
      rd_pending <= 1'b0;
      occ        <= 2'd0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      rd_pending <= ram_re;
      occ        <= occ - {1'b0, pop_ok} + {1'b0, rd_pending};
      if (cfg_we) begin
        out_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      n_reg   <= emit_n;
      rd_addr <= '0;
    end else if (ram_re) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (ram_re) begin
      rd_last <= rd_is_last;
    end
    if (pop_ok && occ == 2'd2) begin
      head_chr  <= tail_chr;
      head_last <= tail_last;
    end
    if (rd_pending) begin
      if (occ == 2'd0 || (occ == 2'd1 && pop_ok)) begin
        head_chr  <= rdata;
        head_last <= rd_last;
      end else begin
        tail_chr  <= rdata;
        tail_last <= rd_last;
      end
    end
  end

endmodule

// ===== rtl/console_line_assembler.sv =====
// Top level of the console line assembler.
//
// Input channel: op and data_byte are taken when push is high and full is low.
// A byte 255 drops itself and the next two bytes, backspace or DEL removes the
// last stored character, printable bytes are stored up to 63 characters, and
// CR or LF ends the line. An item with op set is a session reset of the line.
// Result channel: while empty is low, out_char and last show the oldest
// character; it is taken when pop is high. last marks the end of a line.
// Configuration: cfg_we writes cfg_data into out_limit, which cuts each line
// to out_limit minus one characters. It resets to 64.
// Data flow: an accepted item reaches the line engine through a two-entry
// command queue. After a terminator the characters are read through the
// registered read port of the line store, and a new read can start while
// the previous one is still pending. While a line drains, intake continues
// until the command queue fills, then full holds.
// If pop stays low, a two-entry result buffer fills and the drain pauses.
// Reset clears the line, the command skip and both queues, and sets out_limit
// back to 64.
`timescale 1ns / 1ps
module console_line_assembler import cla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  cmd_req_t    req;
  cmd_status_t q_status;
  logic        q_pop;

  cla_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .op       (op),
    .data_byte(data_byte),
    .q_full   (q_status.full),
    .full     (full),
    .req      (req)
  );

  cla_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .pop   (q_pop),
    .status(q_status)
  );

  cla_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .q_status(q_status),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_char(out_char),
    .last    (last)
  );

endmodule

// ===== rtl/cla_checker.sv =====
// Port-level checker for the console line assembler and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cla_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       last
);

  `CLA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty)
  `CLA_ASSERT_NEXT(a_reset_not_full, clk, 1'b0, rst, !full)
  `CLA_ASSERT_NEXT(a_stall_holds, clk, rst, !empty && !pop, !empty && $stable(out_char) && $stable(last))
  `CLA_ASSERT_SAME(a_known_flags, clk, rst, 1'b1, !$isunknown(empty) && !$isunknown(full))

endmodule

bind console_line_assembler cla_checker u_cla_checker (.*);
